@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/frkc_pkg.sv @@
// ----------------------------------------------------------------------------
// frkc_pkg
// Types, widths and codes of the flow routing convolution unit.
// ----------------------------------------------------------------------------
package frkc_pkg;

  localparam int MAX_TAPS = 64;
  localparam int AW       = $clog2(MAX_TAPS);
  localparam int CW       = $clog2(MAX_TAPS + 1);
  localparam int DW       = 32;
  localparam int TS_W     = 16;
  localparam int MUL_W    = DW + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 2 * DW + AW + 1;
  localparam int LIMB_W   = 24;
  localparam int NLIMB    = (ACC_W + LIMB_W - 1) / LIMB_W;
  localparam int LIMB_CW  = (NLIMB > 1) ? $clog2(NLIMB) : 1;
  localparam int ACC_EXT_W = NLIMB * LIMB_W;
  localparam int SUM_W    = ACC_W + TS_W + 1;
  localparam int FRAC_SH  = 32;
  localparam int WHOLE_W  = SUM_W - FRAC_SH;

  typedef logic [AW-1:0]                addr_t;
  typedef logic [CW-1:0]                cnt_t;
  typedef logic [LIMB_CW-1:0]           limb_t;
  typedef logic signed [MUL_W-1:0]      mul_op_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [ACC_EXT_W-1:0]  acc_ext_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [WHOLE_W-1:0]    whole_t;

  localparam addr_t  LAST_ADDR  = addr_t'(MAX_TAPS - 1);
  localparam cnt_t   CNT_FULL   = cnt_t'(MAX_TAPS);
  localparam limb_t  TOP_LIMB   = limb_t'(NLIMB - 1);
  localparam sum_t   ROUND_BIAS = sum_t'(1) <<< (FRAC_SH - 1);
  localparam whole_t WHOLE_MAX  = whole_t'(64'sd2147483647);
  localparam whole_t WHOLE_MIN  = whole_t'(-64'sd2147483648);
  localparam logic [DW-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] OUT_MIN = 32'h8000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SCALE,
    S_SDRAIN,
    S_ROUND,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic  tap_we;
    addr_t tap_waddr;
    logic  hist_we;
    addr_t hist_waddr;
    logic  rd_en;
    addr_t tap_raddr;
    addr_t hist_raddr;
    logic  acc_clr;
    logic  scale_en;
    limb_t limb_sel;
    logic  sum_clr;
    logic  round_en;
  } ctrl_t;

endpackage

@@ rtl/core/frkc_channels.sv @@
// ----------------------------------------------------------------------------
// frkc channels
// Valid/ready channels for request, result and configuration beats.
// ----------------------------------------------------------------------------
interface frkc_req_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [5:0]          tap_index;
  logic [31:0]         tap_value;
  logic signed [31:0]  flow_sample;

  modport source (output valid, opcode, tap_index, tap_value, flow_sample, input ready);
  modport sink   (input valid, opcode, tap_index, tap_value, flow_sample, output ready);
endinterface

interface frkc_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  routed_flow;
  logic                saturated;

  modport source (output valid, routed_flow, saturated, input ready);
  modport sink   (input valid, routed_flow, saturated, output ready);
endinterface

interface frkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_step;

  modport source (output valid, time_step, input ready);
  modport sink   (input valid, time_step, output ready);
endinterface

@@ rtl/core/frkc_seq.sv @@
// ----------------------------------------------------------------------------
// frkc_seq
// Sequencer: walks the taps, then the scale limbs, rounding and hand-off.
// ----------------------------------------------------------------------------
module frkc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_opcode,
  input  logic [5:0]          req_tap_index,
  input  logic                out_free,
  output logic                req_ready,
  output logic                res_load,
  output frkc_pkg::ctrl_t     ctrl
);

  frkc_pkg::seq_state_t state, state_next;
  frkc_pkg::addr_t      head;
  frkc_pkg::addr_t      ptr;
  frkc_pkg::cnt_t       cnt;
  frkc_pkg::cnt_t       terms;
  frkc_pkg::cnt_t       seen;
  frkc_pkg::limb_t      limb;
  logic                 push_acc;

  assign push_acc = (state == frkc_pkg::S_IDLE) && req_valid
                    && (req_opcode == frkc_pkg::OP_PUSH);

  always_comb begin
    state_next = state;
    case (state)
      frkc_pkg::S_IDLE:   if (push_acc) state_next = frkc_pkg::S_MAC;
      frkc_pkg::S_MAC:    if (cnt == terms) state_next = frkc_pkg::S_DRAIN;
      frkc_pkg::S_DRAIN:  state_next = frkc_pkg::S_SCALE;
      frkc_pkg::S_SCALE:  if (limb == '0) state_next = frkc_pkg::S_SDRAIN;
      frkc_pkg::S_SDRAIN: state_next = frkc_pkg::S_ROUND;
      frkc_pkg::S_ROUND:  state_next = frkc_pkg::S_DONE;
      frkc_pkg::S_DONE:   if (out_free) state_next = frkc_pkg::S_IDLE;
      default:            state_next = frkc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    req_ready = 1'b0;
    res_load  = 1'b0;
    case (state)
      frkc_pkg::S_IDLE: begin
        req_ready       = 1'b1;
        ctrl.tap_we     = req_valid && (req_opcode == frkc_pkg::OP_LOAD)
                          && (int'(req_tap_index) < frkc_pkg::MAX_TAPS);
        ctrl.tap_waddr  = frkc_pkg::addr_t'(req_tap_index);
        ctrl.hist_we    = push_acc;
        ctrl.hist_waddr = head;
        ctrl.acc_clr    = push_acc;
        ctrl.sum_clr    = push_acc;
      end
      frkc_pkg::S_MAC: begin
        ctrl.rd_en      = (cnt != terms);
        ctrl.tap_raddr  = cnt[frkc_pkg::AW-1:0];
        ctrl.hist_raddr = ptr;
      end
      frkc_pkg::S_SCALE: begin
        ctrl.scale_en = 1'b1;
        ctrl.limb_sel = limb;
      end
      frkc_pkg::S_ROUND: ctrl.round_en = 1'b1;
      frkc_pkg::S_DONE:  res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frkc_pkg::S_IDLE;
      head  <= '0;
      ptr   <= '0;
      cnt   <= '0;
      terms <= '0;
      seen  <= '0;
      limb  <= '0;
    end else begin
      state <= state_next;
      case (state)
        frkc_pkg::S_IDLE: begin
          if (push_acc) begin
            ptr   <= head;
            head  <= (head == frkc_pkg::LAST_ADDR) ? '0 : head + 1'b1;
            cnt   <= '0;
            terms <= seen;
            if (seen != frkc_pkg::CNT_FULL) seen <= seen + 1'b1;
          end
        end
        frkc_pkg::S_MAC: begin
          if (cnt != terms) begin
            cnt <= cnt + 1'b1;
            ptr <= (ptr == '0) ? frkc_pkg::LAST_ADDR : ptr - 1'b1;
          end
        end
        frkc_pkg::S_DRAIN: limb <= frkc_pkg::TOP_LIMB;
        frkc_pkg::S_SCALE: if (limb != '0) limb <= limb - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/frkc_mac.sv @@
// ----------------------------------------------------------------------------
// frkc_mac
// Tap and history memories, shared multiplier, accumulator, scale and round.
// ----------------------------------------------------------------------------
module frkc_mac (
  input  logic                clk,
  input  logic                rst,
  input  frkc_pkg::ctrl_t     ctrl,
  input  logic [31:0]         tap_value,
  input  logic signed [31:0]  flow_sample,
  input  logic [15:0]         time_step,
  output logic signed [31:0]  routed_flow,
  output logic                saturated
);

  logic [frkc_pkg::DW-1:0]     taps_mem [frkc_pkg::MAX_TAPS];
  logic [frkc_pkg::DW-1:0]     hist_mem [frkc_pkg::MAX_TAPS];
  logic [frkc_pkg::DW-1:0]     tap_rd;
  logic [frkc_pkg::DW-1:0]     hist_rd;
  logic                        rd_v1;
  logic                        rd_v2;
  logic                        sc_v1;
  frkc_pkg::mul_op_t           mul_a;
  frkc_pkg::mul_op_t           mul_b;
  frkc_pkg::prod_t             prod;
  frkc_pkg::acc_t              acc;
  frkc_pkg::acc_ext_t          acc_ext;
  logic [frkc_pkg::LIMB_W-1:0] limb_bits;
  logic                        top_limb;
  frkc_pkg::sum_t              sum;
  frkc_pkg::sum_t              rounded;
  frkc_pkg::whole_t            whole;

  always_ff @(posedge clk) begin
    if (ctrl.tap_we) taps_mem[ctrl.tap_waddr] <= tap_value;
    tap_rd <= taps_mem[ctrl.tap_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_we) hist_mem[ctrl.hist_waddr] <= flow_sample;
    hist_rd <= hist_mem[ctrl.hist_raddr];
  end

  assign acc_ext   = frkc_pkg::acc_ext_t'(acc);
  assign limb_bits = acc_ext[ctrl.limb_sel * frkc_pkg::LIMB_W +: frkc_pkg::LIMB_W];
  assign top_limb  = (ctrl.limb_sel == frkc_pkg::TOP_LIMB);

  always_comb begin
    if (ctrl.scale_en) begin
      mul_a = {{(frkc_pkg::MUL_W - frkc_pkg::LIMB_W){top_limb & limb_bits[frkc_pkg::LIMB_W-1]}},
               limb_bits};
      mul_b = {{(frkc_pkg::MUL_W - frkc_pkg::TS_W){1'b0}}, time_step};
    end else begin
      mul_a = {{(frkc_pkg::MUL_W - frkc_pkg::DW){hist_rd[frkc_pkg::DW-1]}}, hist_rd};
      mul_b = {{(frkc_pkg::MUL_W - frkc_pkg::DW){1'b0}}, tap_rd};
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1 <= 1'b0;
      rd_v2 <= 1'b0;
      sc_v1 <= 1'b0;
    end else begin
      rd_v1 <= ctrl.rd_en;
      rd_v2 <= rd_v1;
      sc_v1 <= ctrl.scale_en;
    end
  end

  assign rounded = sum + frkc_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (rd_v2) begin
      acc <= acc + frkc_pkg::acc_t'(prod);
    end
    if (ctrl.sum_clr) begin
      sum <= '0;
    end else if (sc_v1) begin
      sum <= (sum <<< frkc_pkg::LIMB_W) + frkc_pkg::sum_t'(prod);
    end
    if (ctrl.round_en) whole <= rounded[frkc_pkg::SUM_W-1:frkc_pkg::FRAC_SH];
  end

  always_comb begin
    if (whole > frkc_pkg::WHOLE_MAX) begin
      routed_flow = frkc_pkg::OUT_MAX;
      saturated   = 1'b1;
    end else if (whole < frkc_pkg::WHOLE_MIN) begin
      routed_flow = frkc_pkg::OUT_MIN;
      saturated   = 1'b1;
    end else begin
      routed_flow = whole[frkc_pkg::DW-1:0];
      saturated   = 1'b0;
    end
  end

endmodule

@@ rtl/core/flow_routing_kernel_convolution_unit.sv @@
// ----------------------------------------------------------------------------
// flow_routing_kernel_convolution_unit
// Load beat: writes a tap, no result. Push beat: the registered result sums
// terms taps, terms = earlier pushes capped at 64, then is scaled and rounded;
// no further beat is taken until that result is loaded into the output register.
// One shared 33x33 multiplier walks one tap per cycle, then three scale limbs.
// Reset clears the sequencer, ring head, sample count and result valid, and
// sets time_step to 1; tap and history memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_routing_kernel_convolution_unit (
  input  logic       clk,
  input  logic       rst,
  frkc_req_if.sink   req,
  frkc_rsp_if.source rsp,
  frkc_cfg_if.sink   cfg
);

  logic                 out_free;
  logic                 res_load;
  logic                 out_valid;
  logic [15:0]          time_step;
  logic signed [31:0]   mac_routed;
  logic                 mac_sat;
  frkc_pkg::ctrl_t      ctrl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd1;
    end else if (cfg.valid) begin
      time_step <= cfg.time_step;
    end
  end

  assign out_free = !out_valid || rsp.ready;

  frkc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_opcode    (req.opcode),
    .req_tap_index (req.tap_index),
    .out_free      (out_free),
    .req_ready     (req.ready),
    .res_load      (res_load),
    .ctrl          (ctrl)
  );

  frkc_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .tap_value   (req.tap_value),
    .flow_sample (req.flow_sample),
    .time_step   (time_step),
    .routed_flow (mac_routed),
    .saturated   (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.routed_flow <= mac_routed;
      rsp.saturated   <= mac_sat;
    end
  end

  assign rsp.valid = out_valid;

  `ASSERT_NXT(a_push_busy, clk, rst, req.valid && req.ready && (req.opcode == frkc_pkg::OP_PUSH), !req.ready, "ready after push beat")
  `ASSERT_IMP(a_sat_extreme, clk, rst, rsp.valid && rsp.saturated, (rsp.routed_flow == frkc_pkg::OUT_MAX) || (rsp.routed_flow == frkc_pkg::OUT_MIN), "saturated result not at a limit")
  `ASSERT_IMP(a_load_free, clk, rst, res_load, !out_valid || rsp.ready, "result register overwritten")
  `ASSERT_NXT(a_load_valid, clk, rst, res_load, out_valid, "loaded result not shown")

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flow routing convolution unit. Loads kernel
// taps and pushes inflow samples over valid/ready, predicts each routed flow
// with an exact wide-integer convolution, and checks every result beat. It
// steps time_step through one, full scale, zero and random values, with
// random idling on both sides, a long result stall and a drained pause.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic               opcode;
    logic [5:0]         tap_index;
    logic [31:0]        tap_value;
    logic signed [31:0] flow_sample;
    bit                 hold;
  } step_item_t;

  typedef struct packed {
    logic signed [31:0] routed;
    logic               sat;
  } flow_out_t;

  logic clk;
  logic rst;

  frkc_req_if req ();
  frkc_rsp_if rsp ();
  frkc_cfg_if cfg ();

  flow_routing_kernel_convolution_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // predictor state
  logic [31:0]        kern_tap [frkc_pkg::MAX_TAPS];
  logic signed [31:0] hist_flow [frkc_pkg::MAX_TAPS];
  frkc_pkg::addr_t    ring_head = '0;
  int                 fill_count = 0;
  logic [15:0]        step_sec = 16'd1;

  flow_out_t  expected_flows [$];
  step_item_t step_queue [$];

  // stimulus bookkeeping
  bit gen_tap_loaded [frkc_pkg::MAX_TAPS];
  int gen_pushes = 0;
  int n_queued   = 0;
  int n_accepted = 0;
  int n_pushed   = 0;
  int n_routed   = 0;
  int errors     = 0;
  int idle_pct   = 0;

  int         send_gap = 0;
  int         recv_gap = 0;
  bit         long_hold_done = 0;
  bit         fire;
  step_item_t nxt;
  flow_out_t  due;

  localparam logic signed [95:0] SUM_MAX = 96'sd2147483647;
  localparam logic signed [95:0] SUM_MIN = -96'sd2147483648;
  localparam logic signed [95:0] HALF_LSB = 96'sd2147483648;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic flow_out_t route_push(input logic signed [31:0] sample);
    logic signed [95:0] acc;
    logic signed [95:0] whole;
    frkc_pkg::addr_t    pos;
    flow_out_t          r;
    hist_flow[ring_head] = sample;
    acc = '0;
    for (int i = 0; i < fill_count; i++) begin
      pos = ring_head - frkc_pkg::addr_t'(i);
      acc += $signed({64'd0, kern_tap[i]})
           * $signed({{64{hist_flow[pos][31]}}, hist_flow[pos]})
           * $signed({80'd0, step_sec});
    end
    whole = (acc + HALF_LSB) >>> 32;
    if (whole > SUM_MAX) begin
      r.routed = frkc_pkg::OUT_MAX;
      r.sat = 1'b1;
    end else if (whole < SUM_MIN) begin
      r.routed = frkc_pkg::OUT_MIN;
      r.sat = 1'b1;
    end else begin
      r.routed = whole[31:0];
      r.sat = 1'b0;
    end
    ring_head = ring_head + frkc_pkg::addr_t'(1);
    if (fill_count < frkc_pkg::MAX_TAPS) fill_count++;
    return r;
  endfunction

  function automatic logic [31:0] rand_tap();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom >> 6;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: begin
        v = int'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        return v;
      end
    endcase
  endfunction

  task automatic add_load(input int idx, input logic [31:0] v);
    step_item_t it;
    it.opcode = frkc_pkg::OP_LOAD;
    it.tap_index = 6'(idx);
    it.tap_value = v;
    it.flow_sample = $urandom;
    it.hold = 1'b0;
    step_queue.push_back(it);
    gen_tap_loaded[idx] = 1'b1;
    n_queued++;
  endtask

  // load any tap this push will read that has never been written
  task automatic add_push(input logic signed [31:0] s, input bit hold);
    step_item_t it;
    int         needs;
    needs = (gen_pushes < frkc_pkg::MAX_TAPS) ? gen_pushes : frkc_pkg::MAX_TAPS;
    for (int t = 0; t < needs; t++)
      if (!gen_tap_loaded[t]) add_load(t, rand_tap());
    it.opcode = frkc_pkg::OP_PUSH;
    it.tap_index = 6'($urandom);
    it.tap_value = $urandom;
    it.flow_sample = s;
    it.hold = hold;
    step_queue.push_back(it);
    gen_pushes++;
    n_queued++;
  endtask

  task automatic add_random(input int n, input int load_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < load_pct)
        add_load($urandom_range(0, frkc_pkg::MAX_TAPS - 1), rand_tap());
      else
        add_push(rand_sample(), 1'b0);
    end
  endtask

  task automatic settle();
    do @(posedge clk); while (n_accepted != n_queued || n_pushed != n_routed);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_time_step(input logic [15:0] v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.time_step <= v;
    do @(posedge clk); while (!cfg.ready);
    step_sec = v;
    cfg.valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.opcode <= frkc_pkg::OP_LOAD;
      req.tap_index <= '0;
      req.tap_value <= '0;
      req.flow_sample <= '0;
      send_gap = 0;
    end else begin
      fire = req.valid && req.ready;
      if (fire) begin
        n_accepted++;
        if (req.opcode == frkc_pkg::OP_PUSH) begin
          expected_flows.push_back(route_push(req.flow_sample));
          n_pushed++;
        end else begin
          kern_tap[req.tap_index] = req.tap_value;
        end
      end
      if (fire || !req.valid) begin
        if (send_gap != 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (step_queue.size() == 0) begin
          req.valid <= 1'b0;
        end else if (step_queue[0].hold && n_pushed != n_routed) begin
          req.valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 6);
          req.valid <= 1'b0;
        end else begin
          nxt = step_queue.pop_front();
          req.valid <= 1'b1;
          req.opcode <= nxt.opcode;
          req.tap_index <= nxt.tap_index;
          req.tap_value <= nxt.tap_value;
          req.flow_sample <= nxt.flow_sample;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      rsp.ready <= 1'b0;
    end else if (!long_hold_done && n_routed == 150) begin
      long_hold_done = 1'b1;
      recv_gap = 600;
      rsp.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(0, 6);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      n_routed <= n_routed + 1;
      if (expected_flows.size() == 0) begin
        $display("%0t: unexpected beat: routed_flow %h saturated %b",
                 $time, rsp.routed_flow, rsp.saturated);
        errors++;
      end else begin
        due = expected_flows.pop_front();
        if (rsp.routed_flow !== due.routed) begin
          $display("%0t: routed_flow expected %h actual %h",
                   $time, due.routed, rsp.routed_flow);
          errors++;
        end
        if (rsp.saturated !== due.sat) begin
          $display("%0t: saturated expected %b actual %b",
                   $time, due.sat, rsp.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.time_step = 16'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset time step, directed extremes and rounding ties
    idle_pct = 15;
    add_push(32'sh7FFF_FFFF, 1'b0);
    add_load(0, 32'h8000_0000);
    add_push(32'sd1, 1'b0);
    add_load(1, 32'h0000_0000);
    add_push(-32'sd1, 1'b0);
    add_load(2, 32'hFFFF_FFFF);
    add_push(32'sh8000_0000, 1'b0);
    add_load(3, 32'hFFFF_FFFF);
    add_push(32'sh7FFF_FFFF, 1'b0);
    add_load(4, 32'h0000_0000);
    add_push(32'sh0000_0000, 1'b0);
    add_load(63, 32'hFFFF_FFFF);
    add_load(5, 32'h0000_0001);
    add_push(32'sh0001_0000, 1'b0);
    add_push(32'sh7FFF_FFFF, 1'b0);
    add_push(32'sh7FFF_FFFF, 1'b0);
    add_random(350, 10);
    settle();

    write_time_step(16'hFFFF);
    add_push(32'sh7FFF_FFFF, 1'b0);
    add_push(32'sh8000_0000, 1'b0);
    add_random(300, 10);
    settle();

    write_time_step(16'd0);
    idle_pct = 30;
    add_random(100, 10);
    settle();

    write_time_step(16'($urandom_range(2, 65534)));
    idle_pct = 0;
    add_random(300, 10);
    settle();

    write_time_step(16'($urandom_range(1, 16)));
    idle_pct = 15;
    add_random(150, 10);
    add_push(rand_sample(), 1'b1);
    add_random(150, 10);
    settle();

    write_time_step(16'd1);
    idle_pct = 0;
    add_random(300, 10);
    settle();

    if (expected_flows.size() != 0) begin
      $display("%0t: %0d routed_flow beats never arrived", $time, expected_flows.size());
      errors++;
    end
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #(20 * 1_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
